// ===== rtl/core/ecs_pkg.sv =====
// ============================================================================
// ecs_pkg
// Shared types and constants for the escape command splitter.
// ============================================================================
package ecs_pkg;

    // Longest command line that is kept; longer lines are reported as too long.
    localparam int LINE_CAPACITY = 256;
    localparam int COUNT_W       = $clog2(LINE_CAPACITY + 1);

    localparam int BYTE_W      = 8;
    localparam int CHAR_W      = 7;
    localparam int KIND_W      = 3;
    localparam int CMD_LEN_W   = 9;
    localparam int CFG_DATA_W  = 7;
    localparam int CFG_INDEX_W = 2;
    localparam int MAX_RESULTS = 3;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
    localparam int RES_IDX_W   = $clog2(MAX_RESULTS);

    localparam logic [BYTE_W-1:0] CH_CR          = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF          = 8'h0A;
    localparam logic [CHAR_W-1:0] ESC_CHAR_RESET = 7'd94;

    typedef enum logic [KIND_W-1:0] {
        KIND_NET  = 3'd0,
        KIND_ECHO = 3'd1,
        KIND_CMD  = 3'd2,
        KIND_DONE = 3'd3,
        KIND_LONG = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_ESCAPED = 2'd1,
        MODE_COMMAND = 2'd2
    } mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ESCAPE_ENABLE = 2'd0,
        CFG_ESCAPE_CHAR   = 2'd1,
        CFG_BINARY_MODE   = 2'd2,
        CFG_ECHO_COMMANDS = 2'd3
    } cfg_index_t;

    // What one input byte does, decided from the mode and the byte class.
    typedef enum logic [1:0] {
        PATH_NETWORK = 2'd0,
        PATH_ENTER   = 2'd1,
        PATH_FINISH  = 2'd2,
        PATH_COLLECT = 2'd3
    } path_t;

    typedef struct packed {
        logic              escape_enable;
        logic [CHAR_W-1:0] escape_char;
        logic              binary_mode;
        logic              echo_commands;
    } cfg_t;

    typedef struct packed {
        mode_t              mode;
        logic [COUNT_W-1:0] stored_count;
        logic               truncated;
    } state_t;

    typedef struct packed {
        kind_t                kind;
        logic [BYTE_W-1:0]    out_byte;
        logic [CMD_LEN_W-1:0] cmd_length;
    } result_t;

    typedef struct packed {
        logic [RES_CNT_W-1:0]          count;
        result_t [MAX_RESULTS-1:0]     entry;
    } res_list_t;

endpackage

// ===== rtl/core/ecs_key_if.sv =====
// ============================================================================
// ecs_key_if
// Input channel carrying one raw keyboard byte per transaction.
// ============================================================================
interface ecs_key_if import ecs_pkg::*;;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);

endinterface

// ===== rtl/core/ecs_res_if.sv =====
// ============================================================================
// ecs_res_if
// Result channel carrying one classified result per transaction.
// ============================================================================
interface ecs_res_if import ecs_pkg::*;;

    logic                 valid;
    logic                 ready;
    kind_t                kind;
    logic [BYTE_W-1:0]    out_byte;
    logic [CMD_LEN_W-1:0] cmd_length;
    logic                 last;

    modport source (output valid, output kind, output out_byte, output cmd_length,
                    output last, input ready);
    modport sink   (input valid, input kind, input out_byte, input cmd_length,
                    input last, output ready);

endinterface

// ===== rtl/core/ecs_step.sv =====
// ============================================================================
// ecs_step
// Combinational decision for one byte: next mode state and result list.
// ============================================================================
module ecs_step import ecs_pkg::*;
(
    input  logic [BYTE_W-1:0] in_byte,
    input  cfg_t              cfg,
    input  state_t            state,
    output state_t            state_next,
    output res_list_t         list
);

    logic [CHAR_W-1:0] low;
    logic              is_esc;
    logic              is_end;
    logic              is_cr_full;
    logic              has_room;
    path_t             path;

    assign low        = in_byte[CHAR_W-1:0];
    assign is_esc     = cfg.escape_enable && (low == cfg.escape_char);
    assign is_end     = !is_esc && ((low == CH_CR[CHAR_W-1:0]) || (low == CH_LF[CHAR_W-1:0]));
    assign is_cr_full = (in_byte == CH_CR);
    assign has_room   = (state.stored_count < COUNT_W'(LINE_CAPACITY));

    function automatic result_t make_result(kind_t k, logic [BYTE_W-1:0] b,
                                            logic [CMD_LEN_W-1:0] len);
        result_t r;
        r.kind       = k;
        r.out_byte   = b;
        r.cmd_length = len;
        return r;
    endfunction

    // Classify the byte against the current mode. The unused mode code acts
    // like an open command.
    always_comb
    begin
        case (state.mode)
            MODE_IDLE:    path = is_esc ? PATH_ENTER : PATH_NETWORK;
            MODE_ESCAPED: path = is_esc ? PATH_NETWORK : (is_end ? PATH_FINISH : PATH_COLLECT);
            default:      path = is_end ? PATH_FINISH : PATH_COLLECT;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state;
        case (path)
            PATH_NETWORK:
            begin
                state_next.mode = MODE_IDLE;
            end
            PATH_ENTER:
            begin
                state_next.mode         = MODE_ESCAPED;
                state_next.stored_count = '0;
                state_next.truncated    = 1'b0;
            end
            PATH_FINISH:
            begin
                state_next.mode = MODE_IDLE;
            end
            default:
            begin
                state_next.mode = MODE_COMMAND;
                if (has_room)
                begin
                    state_next.stored_count = state.stored_count + COUNT_W'(1);
                end
                else
                begin
                    state_next.truncated = 1'b1;
                end
            end
        endcase
    end

    // Result list, filled in order from entry zero.
    always_comb
    begin
        logic [RES_CNT_W-1:0] n;
        n          = '0;
        list.entry = '0;
        case (path)
            PATH_NETWORK:
            begin
                list.entry[RES_IDX_W'(n)] = make_result(KIND_NET, in_byte, '0);
                n = n + RES_CNT_W'(1);
                if (is_cr_full && !cfg.binary_mode)
                begin
                    list.entry[RES_IDX_W'(n)] = make_result(KIND_NET, CH_LF, '0);
                    n = n + RES_CNT_W'(1);
                end
            end
            PATH_ENTER:
            begin
                if (cfg.echo_commands)
                begin
                    list.entry[RES_IDX_W'(n)] = make_result(KIND_ECHO, in_byte, '0);
                    n = n + RES_CNT_W'(1);
                end
            end
            PATH_FINISH:
            begin
                if (cfg.echo_commands)
                begin
                    list.entry[RES_IDX_W'(n)] = make_result(KIND_ECHO, CH_CR, '0);
                    n = n + RES_CNT_W'(1);
                    list.entry[RES_IDX_W'(n)] = make_result(KIND_ECHO, CH_LF, '0);
                    n = n + RES_CNT_W'(1);
                end
                if (state.truncated)
                begin
                    list.entry[RES_IDX_W'(n)] = make_result(KIND_LONG, '0, '0);
                end
                else
                begin
                    list.entry[RES_IDX_W'(n)] =
                        make_result(KIND_DONE, '0, CMD_LEN_W'(state.stored_count));
                end
                n = n + RES_CNT_W'(1);
            end
            default:
            begin
                if (cfg.echo_commands)
                begin
                    list.entry[RES_IDX_W'(n)] = make_result(KIND_ECHO, in_byte, '0);
                    n = n + RES_CNT_W'(1);
                end
                if (has_room)
                begin
                    list.entry[RES_IDX_W'(n)] = make_result(KIND_CMD, in_byte, '0);
                    n = n + RES_CNT_W'(1);
                end
            end
        endcase
        list.count = n;
    end

endmodule

// ===== rtl/core/escape_command_splitter_core.sv =====
// ============================================================================
// escape_command_splitter_core
// Splits keyboard bytes into network bytes, echo bytes and local command lines.
// ============================================================================
//
//   Channel   Direction  Transaction payload
//   keys      in         in_byte: one raw keyboard byte
//   results   out        kind, out_byte, cmd_length, last
//   cfg_*     in         plain register write: cfg_we, cfg_index, cfg_data
//
// A byte accepted on keys is held in the input register and then is
// decoded in one pass into a list of zero to three results. The list drains
// through the single results channel at one transaction per cycle while
// results is ready, so bytes producing one result stream at one per cycle
// unless results stalls. A byte passes the input register and then the list
// register before its first result appears. The input register takes the next
// byte while the list still drains, and a stall on results holds both stages.
// Reset brings the registers to their documented defaults and empties both
// stages.
//
module escape_command_splitter_core import ecs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    ecs_key_if.sink                keys,
    ecs_res_if.source              results,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Configuration registers. The user writes them only while the block is idle; the block does not enforce it.
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.escape_enable <= 1'b1;
            cfg_reg.escape_char   <= ESC_CHAR_RESET;
            cfg_reg.binary_mode   <= 1'b0;
            cfg_reg.echo_commands <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ESCAPE_ENABLE: cfg_reg.escape_enable <= cfg_data[0];
                CFG_ESCAPE_CHAR:   cfg_reg.escape_char   <= cfg_data[CHAR_W-1:0];
                CFG_BINARY_MODE:   cfg_reg.binary_mode   <= cfg_data[0];
                CFG_ECHO_COMMANDS: cfg_reg.echo_commands <= cfg_data[0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Input register stage.
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // Result list stage: the list is the result register. The read index walks
    // the entries one per transaction.
    res_list_t            list_reg;
    logic [RES_CNT_W-1:0] res_idx_reg;
    logic [RES_CNT_W-1:0] res_idx_inc;
    logic                 res_pending;
    logic                 pop;
    logic                 list_free;
    logic                 load;

    // Mode state follows each byte as it is decoded.
    state_t    state_reg;
    state_t    state_next;
    res_list_t list_next;

    ecs_step u_step
    (
        .in_byte    (in_byte_reg),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .state_next (state_next),
        .list       (list_next)
    );

    assign res_idx_inc = res_idx_reg + RES_CNT_W'(1);
    assign res_pending = (res_idx_reg != list_reg.count);
    assign pop         = results.valid && results.ready;
    // The list can take a new byte once its final entry leaves.
    assign list_free   = !res_pending || (pop && (res_idx_inc == list_reg.count));
    assign load        = in_valid_reg && list_free;
    assign keys.ready  = !in_valid_reg || load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (keys.ready)
        begin
            in_valid_reg <= keys.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (keys.valid && keys.ready)
        begin
            in_byte_reg <= keys.in_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode         <= MODE_IDLE;
            state_reg.stored_count <= '0;
            state_reg.truncated    <= 1'b0;
            list_reg               <= '0;
            res_idx_reg            <= '0;
        end
        else if (load)
        begin
            state_reg   <= state_next;
            list_reg    <= list_next;
            res_idx_reg <= '0;
        end
        else if (pop)
        begin
            res_idx_reg <= res_idx_inc;
        end
    end

    // The pending entry drives the result channel directly.
    result_t head;

    assign head               = list_reg.entry[res_idx_reg[RES_IDX_W-1:0]];
    assign results.valid      = res_pending;
    assign results.kind       = head.kind;
    assign results.out_byte   = head.out_byte;
    assign results.cmd_length = head.cmd_length;
    assign results.last       = (res_idx_inc == list_reg.count);

`ifndef ASSERT_OFF
    // The read index never runs past the end of the list.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_idx_reg <= list_reg.count)
        else $error("result read index passed the list length");

    // The stored length never exceeds the line capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.stored_count <= COUNT_W'(LINE_CAPACITY))
        else $error("stored command length above capacity");

    // A line is only marked truncated once it is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.truncated |-> (state_reg.stored_count == COUNT_W'(LINE_CAPACITY)))
        else $error("truncated flag set on a line that is not full");

    // Right after the escape character nothing is stored yet.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.mode == MODE_ESCAPED) |->
            ((state_reg.stored_count == '0) && !state_reg.truncated))
        else $error("escape mode entered with a non-empty line");

    // Loading a new list restarts the read index at its first entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (res_idx_reg == '0))
        else $error("result list load did not restart the read index");
`endif

endmodule

// ===== test/tb_top.sv =====
// ============================================================================
// tb_top
// Self-checking bench for escape_command_splitter_core. A table of directed
// keyboard bytes and register writes runs first. It is followed by phases of
// random escape sequences under different register settings, by two full-length
// command lines and a short one. Results are compared with an in-bench model
// of the splitter, or on typed rows with their hand-written result.
// ============================================================================
module tb_top import ecs_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 8;
    localparam int MAX_GAP         = 10;
    // A byte passes the input and list registers before its first result;
    // the settle time also covers a byte that is decoded but yields nothing.
    localparam int SETTLE_CYCLES   = 6;
    localparam int HOLD_CYCLES     = 200;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 44;
    // About 900 bytes, each costing at most a sender gap of up to MAX_GAP plus
    // three results behind receiver stalls of up to MAX_GAP each, so this limit
    // leaves a wide margin.
    localparam int CYCLE_LIMIT     = 400000;

    typedef enum bit {
        ROW_KEY,
        ROW_CFG
    } row_op_t;

    // One line of the directed table: either a byte to send or a register
    // write. Rows marked typed carry their single result written out by hand.
    typedef struct {
        row_op_t              op;
        cfg_index_t           reg_idx;
        logic [BYTE_W-1:0]    value;
        bit                   typed;
        kind_t                exp_kind;
        logic [BYTE_W-1:0]    exp_byte;
        logic [CMD_LEN_W-1:0] exp_len;
    } stim_row_t;

    typedef struct {
        kind_t                kind;
        logic [BYTE_W-1:0]    out_byte;
        logic [CMD_LEN_W-1:0] cmd_length;
        logic                 last;
    } split_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    ecs_key_if keys_ch ();
    ecs_res_if res_ch ();

    escape_command_splitter_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .keys      (keys_ch),
        .results   (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Model state: the register copy, the line mode, the stored length and
    // the truncation flag, kept in step with every accepted transaction.
    cfg_t        model_cfg;
    mode_t       model_mode;
    int unsigned model_count;
    bit          model_truncated;

    // Results still owed by the block, oldest first, and the scratch list
    // that the model fills for a single byte.
    split_result_t awaited_results[$];
    split_result_t fresh_results[$];
    stim_row_t     directed_rows[$];

    int          mismatch_count;
    int          results_seen;
    int unsigned cycle_count;
    bit          no_idle;
    bit          hold_request;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Watchdog. If the run has not finished by the limit, something hangs.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Splitter model
    // ------------------------------------------------------------------------

    function automatic void add_result(kind_t k, logic [BYTE_W-1:0] b,
                                       logic [CMD_LEN_W-1:0] len);
        split_result_t r;
        r.kind       = k;
        r.out_byte   = b;
        r.cmd_length = len;
        r.last       = 1'b0;
        fresh_results.push_back(r);
    endfunction

    // A byte headed for the network. A full eight-bit CR gets an LF after it
    // unless binary mode is on. Either way the line mode returns to idle.
    function automatic void pass_to_network(logic [BYTE_W-1:0] c);
        add_result(KIND_NET, c, '0);
        if (c == CH_CR && !model_cfg.binary_mode)
            add_result(KIND_NET, CH_LF, '0);
        model_mode = MODE_IDLE;
    endfunction

    // Works out the results of one accepted byte into fresh_results and
    // advances the model state.
    function automatic void split_byte(logic [BYTE_W-1:0] c);
        logic [CHAR_W-1:0] low;
        bit                is_esc;
        bit                is_end;
        fresh_results.delete();
        low    = c[CHAR_W-1:0];
        // The escape test takes priority over the line-end test.
        is_esc = model_cfg.escape_enable && (low == model_cfg.escape_char);
        is_end = !is_esc && (low == CH_CR[CHAR_W-1:0] || low == CH_LF[CHAR_W-1:0]);
        if (model_mode == MODE_IDLE)
        begin
            if (is_esc)
            begin
                // Entering command mode starts a fresh, untruncated line.
                model_mode      = MODE_ESCAPED;
                model_count     = 0;
                model_truncated = 1'b0;
                if (model_cfg.echo_commands)
                    add_result(KIND_ECHO, c, '0);
            end
            else
            begin
                pass_to_network(c);
            end
        end
        else if (model_mode == MODE_ESCAPED && is_esc)
        begin
            // A doubled escape sends one copy of itself to the network.
            pass_to_network(c);
        end
        else if (is_end)
        begin
            if (model_cfg.echo_commands)
            begin
                add_result(KIND_ECHO, CH_CR, '0);
                add_result(KIND_ECHO, CH_LF, '0);
            end
            if (model_truncated)
                add_result(KIND_LONG, '0, '0);
            else
                add_result(KIND_DONE, '0, model_count[CMD_LEN_W-1:0]);
            model_mode = MODE_IDLE;
        end
        else
        begin
            // A command byte. Once the line is full it is still echoed but
            // no longer stored, and the line is marked too long.
            if (model_cfg.echo_commands)
                add_result(KIND_ECHO, c, '0);
            if (model_count < LINE_CAPACITY)
            begin
                add_result(KIND_CMD, c, '0);
                model_count++;
            end
            else
            begin
                model_truncated = 1'b1;
            end
            model_mode = MODE_COMMAND;
        end
        if (fresh_results.size() != 0)
            fresh_results[fresh_results.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Directed table rows
    // ------------------------------------------------------------------------

    function automatic stim_row_t key_row(logic [BYTE_W-1:0] v);
        key_row = '{ROW_KEY, CFG_ESCAPE_ENABLE, v, 1'b0, KIND_NET, '0, '0};
    endfunction

    function automatic stim_row_t typed_row(logic [BYTE_W-1:0] v, kind_t k,
                                            logic [BYTE_W-1:0] b,
                                            logic [CMD_LEN_W-1:0] len);
        typed_row = '{ROW_KEY, CFG_ESCAPE_ENABLE, v, 1'b1, k, b, len};
    endfunction

    function automatic stim_row_t cfg_row(cfg_index_t idx, logic [BYTE_W-1:0] v);
        cfg_row = '{ROW_CFG, idx, v, 1'b0, KIND_NET, '0, '0};
    endfunction

    // ------------------------------------------------------------------------
    // Byte generators for the random part
    // ------------------------------------------------------------------------

    // The current escape character, with a random top bit. The top bit must
    // not matter to the escape test.
    function automatic logic [BYTE_W-1:0] escape_byte();
        escape_byte = {1'($urandom_range(0, 1)), model_cfg.escape_char};
    endfunction

    // Any byte except one whose low seven bits read as CR or LF.
    function automatic logic [BYTE_W-1:0] command_filler();
        logic [BYTE_W-1:0] b;
        b = 8'($urandom_range(0, 255));
        if (b[CHAR_W-1:0] == CH_CR[CHAR_W-1:0] || b[CHAR_W-1:0] == CH_LF[CHAR_W-1:0])
            b[0] = ~b[0];
        return b;
    endfunction

    // CR or LF, random top bit, avoiding the one that is currently the escape.
    function automatic logic [BYTE_W-1:0] line_end();
        logic [BYTE_W-1:0] b;
        b = $urandom_range(0, 1) ? CH_CR : CH_LF;
        if (model_cfg.escape_enable && b[CHAR_W-1:0] == model_cfg.escape_char)
            b = (b == CH_CR) ? CH_LF : CH_CR;
        b[BYTE_W-1] = 1'($urandom_range(0, 1));
        return b;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch at result %0d: %s", $realtime, results_seen, msg);
        mismatch_count++;
    endtask

    // Offers one byte on keys after a random gap and waits for the transaction.
    // A typed row replaces the model's results with its hand-written one. The
    // model still runs so that its state stays in step.
    task automatic send_key(input logic [BYTE_W-1:0] c, input bit typed = 1'b0,
                            input split_result_t typed_res = '{KIND_NET, 8'h00, 9'd0, 1'b1});
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap != 0)
        begin
            keys_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        keys_ch.valid   = 1'b1;
        keys_ch.in_byte = c;
        do
            @(posedge clk);
        while (keys_ch.ready !== 1'b1);
        split_byte(c);
        if (typed)
        begin
            awaited_results.push_back(typed_res);
        end
        else
        begin
            foreach (fresh_results[i])
                awaited_results.push_back(fresh_results[i]);
        end
    endtask

    // The sender stops and waits until the block has delivered everything.
    // It also waits out a byte that may still be decoding without a result.
    task automatic wait_for_idle();
        @(negedge clk);
        keys_ch.valid = 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        wait_for_idle();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_ESCAPE_ENABLE: model_cfg.escape_enable = val[0];
            CFG_ESCAPE_CHAR:   model_cfg.escape_char   = val[CHAR_W-1:0];
            CFG_BINARY_MODE:   model_cfg.binary_mode   = val[0];
            CFG_ECHO_COMMANDS: model_cfg.echo_commands = val[0];
            default: ;
        endcase
    endtask

    // One command line of a given length. The first stored byte is a plain
    // letter, so that it cannot be read as a doubled escape.
    task automatic send_long_line(input int stored);
        send_key(escape_byte());
        send_key(8'h41);
        repeat (stored - 1) send_key(command_filler());
        send_key(line_end());
    endtask

    // ------------------------------------------------------------------------
    // Result receiver and checker
    // ------------------------------------------------------------------------

    // Each result transaction gets its own random stall on ready. Once, when
    // asked, the receiver holds ready low for a long count so that both
    // stages fill up and keys back up.
    initial
    begin
        int stall;
        bit hold_done;
        split_result_t want;
        res_ch.ready = 1'b0;
        hold_done    = 1'b0;
        results_seen = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_done)
            begin
                res_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (stall != 0)
            begin
                res_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ch.ready = 1'b1;
            do
                @(posedge clk);
            while (res_ch.valid !== 1'b1);
            results_seen++;
            if (awaited_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result kind %0d byte %h len %0d",
                                          res_ch.kind, res_ch.out_byte, res_ch.cmd_length));
            end
            else
            begin
                want = awaited_results.pop_front();
                if (res_ch.kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, expected %0d",
                                              res_ch.kind, want.kind));
                if (res_ch.out_byte !== want.out_byte)
                    report_mismatch($sformatf("out_byte %h, expected %h",
                                              res_ch.out_byte, want.out_byte));
                if (res_ch.cmd_length !== want.cmd_length)
                    report_mismatch($sformatf("cmd_length %0d, expected %0d",
                                              res_ch.cmd_length, want.cmd_length));
                if (res_ch.last !== want.last)
                    report_mismatch($sformatf("last %b, expected %b",
                                              res_ch.last, want.last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        int                    sent;
        int                    len;
        int                    pick;
        logic [CFG_DATA_W-1:0] esc_sel;
        split_result_t         typed_res;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_ESCAPE_ENABLE;
        cfg_data        = '0;
        keys_ch.valid   = 1'b0;
        keys_ch.in_byte = '0;
        mismatch_count  = 0;
        no_idle         = 1'b0;
        hold_request    = 1'b0;
        model_cfg       = '{1'b1, ESC_CHAR_RESET, 1'b0, 1'b0};
        model_mode      = MODE_IDLE;
        model_count     = 0;
        model_truncated = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, starting from the reset settings (escape '^').
        // It covers the byte extremes, the full-byte CR rule, a doubled
        // escape, and an escape stored inside a command. It also covers
        // echo, a command that stays open while escape recognition is off,
        // and the escape characters 127 and 0. Last comes an escape character
        // equal to CR, which must win over the line-end test.
        directed_rows = '{
            typed_row(8'h00, KIND_NET, 8'h00, 9'd0),
            typed_row(8'hFF, KIND_NET, 8'hFF, 9'd0),
            key_row(8'h0D),
            key_row(8'h8D),
            key_row(8'h5E),
            typed_row(8'hDE, KIND_NET, 8'hDE, 9'd0),
            key_row(8'h5E),
            key_row(8'h61),
            key_row(8'h5E),
            typed_row(8'h8A, KIND_DONE, 8'h00, 9'd2),
            cfg_row(CFG_ECHO_COMMANDS, 8'd1),
            typed_row(8'h5E, KIND_ECHO, 8'h5E, 9'd0),
            key_row(8'h41),
            key_row(8'h0A),
            typed_row(8'h5E, KIND_ECHO, 8'h5E, 9'd0),
            cfg_row(CFG_ESCAPE_ENABLE, 8'd0),
            key_row(8'h7A),
            key_row(8'h5E),
            key_row(8'h0D),
            cfg_row(CFG_ESCAPE_ENABLE, 8'd1),
            cfg_row(CFG_ESCAPE_CHAR, 8'd127),
            cfg_row(CFG_BINARY_MODE, 8'd1),
            typed_row(8'hFF, KIND_ECHO, 8'hFF, 9'd0),
            typed_row(8'h7F, KIND_NET, 8'h7F, 9'd0),
            typed_row(8'h0D, KIND_NET, 8'h0D, 9'd0),
            cfg_row(CFG_ESCAPE_CHAR, 8'd0),
            typed_row(8'h80, KIND_ECHO, 8'h80, 9'd0),
            key_row(8'h0A),
            cfg_row(CFG_ESCAPE_CHAR, 8'd13),
            cfg_row(CFG_ECHO_COMMANDS, 8'd0),
            cfg_row(CFG_BINARY_MODE, 8'd0),
            key_row(8'h8D),
            key_row(8'h0D)
        };

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].op == ROW_CFG)
            begin
                write_register(directed_rows[i].reg_idx,
                               directed_rows[i].value[CFG_DATA_W-1:0]);
            end
            else if (directed_rows[i].typed)
            begin
                typed_res = '{directed_rows[i].exp_kind, directed_rows[i].exp_byte,
                              directed_rows[i].exp_len, 1'b1};
                send_key(directed_rows[i].value, 1'b1, typed_res);
            end
            else
            begin
                send_key(directed_rows[i].value);
            end
        end

        // Random phases. Each phase writes every register and then sends
        // mostly well-formed escape sequences with random content: command
        // lines, doubled escapes, and runs of loose bytes in between. The
        // phases use escape characters 0 and 127, one equal to CR, and phases
        // with recognition off. Every third phase runs with no idle cycles.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       esc_sel = ESC_CHAR_RESET;
                1:       esc_sel = 7'd0;
                3:       esc_sel = 7'd127;
                5:       esc_sel = CH_CR[CHAR_W-1:0];
                default: esc_sel = 7'($urandom_range(0, 127));
            endcase
            write_register(CFG_ESCAPE_ENABLE, (phase == 2 || phase == 6) ? 7'd0 : 7'd1);
            write_register(CFG_ESCAPE_CHAR, esc_sel);
            write_register(CFG_BINARY_MODE, 7'(phase % 2));
            write_register(CFG_ECHO_COMMANDS, 7'((phase / 2) % 2));
            no_idle = (phase % 3 == 1);
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    len = $urandom_range(0, 12);
                    send_key(escape_byte());
                    repeat (len) send_key(command_filler());
                    send_key(line_end());
                    sent += len + 2;
                end
                else if (pick < 75)
                begin
                    send_key(escape_byte());
                    send_key(escape_byte());
                    sent += 2;
                end
                else
                begin
                    len = $urandom_range(1, 4);
                    repeat (len) send_key(8'($urandom_range(0, 255)));
                    sent += len;
                end
            end
        end

        // Full lines. The first line fills the buffer exactly, so the command
        // completes with the largest length. It runs with echo on, and the
        // receiver makes its long hold during it. The second line overflows
        // by a few bytes and has to come back as too long.
        no_idle = 1'b0;
        write_register(CFG_ESCAPE_ENABLE, 7'd1);
        write_register(CFG_ESCAPE_CHAR, ESC_CHAR_RESET);
        write_register(CFG_BINARY_MODE, 7'd0);
        write_register(CFG_ECHO_COMMANDS, 7'd1);
        hold_request = 1'b1;
        send_long_line(LINE_CAPACITY);
        write_register(CFG_ECHO_COMMANDS, 7'd0);
        no_idle = 1'b1;
        send_long_line(LINE_CAPACITY + $urandom_range(1, 8));
        // A short line afterwards checks that the truncation flag is cleared.
        no_idle = 1'b0;
        send_long_line(3);

        // Drain. The block must owe nothing, and nothing may arrive after
        // the last expected result.
        wait_for_idle();
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
